// ===== rtl/fcla_pkg.sv =====
// fcla_pkg: types, constants and the dB ROM for the floor curve line renderer.
// No dependencies.
package fcla_pkg;

  localparam logic [1:0] OP_COEF  = 2'd0;
  localparam logic [1:0] OP_POST  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;
  localparam logic [1:0] OP_RSVD  = 2'd3;

  localparam logic [7:0]  Y_MAX   = 8'd255;
  localparam logic [12:0] BIN_MAX = 13'd8191;
  localparam int          SHIFT   = 15;

  localparam logic [1:0] ADDR_MULT = 2'd0;
  localparam logic [1:0] ADDR_HALF = 2'd1;

  // commands from controller to datapath
  typedef struct packed {
    logic start;      // frame start item
    logic post_load;  // latch post, begin division
    logic div_step;   // one restoring division step
    logic post_done;  // commit segment parameters
    logic coef_load;  // register coefficient bin
    logic mul_load;   // product stage
    logic out_load;   // result register load
  } fcla_cmd_t;

  typedef struct packed {
    logic div_last;   // final division step this cycle
  } fcla_sts_t;

  function automatic logic [31:0] db_rom(input logic [7:0] i);
    logic [31:0] r;
    case (i)
      8'd0: r=229; 8'd1: r=244; 8'd2: r=259; 8'd3: r=276; 8'd4: r=294; 8'd5: r=313;
      8'd6: r=334; 8'd7: r=355; 8'd8: r=378; 8'd9: r=403; 8'd10: r=429; 8'd11: r=457;
      8'd12: r=487; 8'd13: r=518; 8'd14: r=552; 8'd15: r=588; 8'd16: r=626; 8'd17: r=667;
      8'd18: r=710; 8'd19: r=756; 8'd20: r=806; 8'd21: r=858; 8'd22: r=914; 8'd23: r=973;
      8'd24: r=1036; 8'd25: r=1104; 8'd26: r=1175; 8'd27: r=1252; 8'd28: r=1333;
      8'd29: r=1420; 8'd30: r=1512; 8'd31: r=1610; 8'd32: r=1715; 8'd33: r=1826;
      8'd34: r=1945; 8'd35: r=2072; 8'd36: r=2206; 8'd37: r=2350; 8'd38: r=2502;
      8'd39: r=2665; 8'd40: r=2838; 8'd41: r=3023; 8'd42: r=3219; 8'd43: r=3428;
      8'd44: r=3651; 8'd45: r=3888; 8'd46: r=4141; 8'd47: r=4410; 8'd48: r=4696;
      8'd49: r=5002; 8'd50: r=5327; 8'd51: r=5673; 8'd52: r=6042; 8'd53: r=6434;
      8'd54: r=6852; 8'd55: r=7298; 8'd56: r=7772; 8'd57: r=8277; 8'd58: r=8815;
      8'd59: r=9388; 8'd60: r=9998; 8'd61: r=10647; 8'd62: r=11339; 8'd63: r=12076;
      8'd64: r=12861; 8'd65: r=13697; 8'd66: r=14587; 8'd67: r=15535; 8'd68: r=16544;
      8'd69: r=17619; 8'd70: r=18764; 8'd71: r=19984; 8'd72: r=21283; 8'd73: r=22666;
      8'd74: r=24139; 8'd75: r=25707; 8'd76: r=27378; 8'd77: r=29157; 8'd78: r=31052;
      8'd79: r=33070; 8'd80: r=35219; 8'd81: r=37507; 8'd82: r=39945; 8'd83: r=42541;
      8'd84: r=45305; 8'd85: r=48249; 8'd86: r=51385; 8'd87: r=54724; 8'd88: r=58281;
      8'd89: r=62068; 8'd90: r=66101; 8'd91: r=70397; 8'd92: r=74972; 8'd93: r=79844;
      8'd94: r=85033; 8'd95: r=90559; 8'd96: r=96444; 8'd97: r=102711; 8'd98: r=109386;
      8'd99: r=116494; 8'd100: r=124065; 8'd101: r=132127; 8'd102: r=140714;
      8'd103: r=149858; 8'd104: r=159597; 8'd105: r=169968; 8'd106: r=181014;
      8'd107: r=192777; 8'd108: r=205305; 8'd109: r=218646; 8'd110: r=232855;
      8'd111: r=247988; 8'd112: r=264103; 8'd113: r=281266; 8'd114: r=299544;
      8'd115: r=319011; 8'd116: r=339742; 8'd117: r=361820; 8'd118: r=385333;
      8'd119: r=410374; 8'd120: r=437043; 8'd121: r=465444; 8'd122: r=495691;
      8'd123: r=527904; 8'd124: r=562210; 8'd125: r=598746; 8'd126: r=637656;
      8'd127: r=679094; 8'd128: r=723226; 8'd129: r=770225; 8'd130: r=820278;
      8'd131: r=873585; 8'd132: r=930355; 8'd133: r=990815; 8'd134: r=1055204;
      8'd135: r=1123777; 8'd136: r=1196806; 8'd137: r=1274581; 8'd138: r=1357411;
      8'd139: r=1445623; 8'd140: r=1539568; 8'd141: r=1639617; 8'd142: r=1746169;
      8'd143: r=1859645; 8'd144: r=1980495; 8'd145: r=2109199; 8'd146: r=2246266;
      8'd147: r=2392241; 8'd148: r=2547703; 8'd149: r=2713267; 8'd150: r=2889590;
      8'd151: r=3077372; 8'd152: r=3277357; 8'd153: r=3490338; 8'd154: r=3717160;
      8'd155: r=3958722; 8'd156: r=4215982; 8'd157: r=4489960; 8'd158: r=4781743;
      8'd159: r=5092488; 8'd160: r=5423426; 8'd161: r=5775871; 8'd162: r=6151219;
      8'd163: r=6550960; 8'd164: r=6976679; 8'd165: r=7430063; 8'd166: r=7912910;
      8'd167: r=8427135; 8'd168: r=8974778; 8'd169: r=9558009; 8'd170: r=10179143;
      8'd171: r=10840641; 8'd172: r=11545127; 8'd173: r=12295394; 8'd174: r=13094418;
      8'd175: r=13945367; 8'd176: r=14851616; 8'd177: r=15816757; 8'd178: r=16844619;
      8'd179: r=17939278; 8'd180: r=19105073; 8'd181: r=20346628; 8'd182: r=21668866;
      8'd183: r=23077031; 8'd184: r=24576707; 8'd185: r=26173840; 8'd186: r=27874763;
      8'd187: r=29686223; 8'd188: r=31615400; 8'd189: r=33669947; 8'd190: r=35858010;
      8'd191: r=38188266; 8'd192: r=40669954; 8'd193: r=43312918; 8'd194: r=46127635;
      8'd195: r=49125267; 8'd196: r=52317705; 8'd197: r=55717604; 8'd198: r=59338448;
      8'd199: r=63194594; 8'd200: r=67301334; 8'd201: r=71674955; 8'd202: r=76332796;
      8'd203: r=81293331; 8'd204: r=86576231; 8'd205: r=92202442; 8'd206: r=98194276;
      8'd207: r=104575492; 8'd208: r=111371397; 8'd209: r=118608939;
      8'd210: r=126316814; 8'd211: r=134525593; 8'd212: r=143267823;
      8'd213: r=152578174; 8'd214: r=162493564; 8'd215: r=173053310;
      8'd216: r=184299289; 8'd217: r=196276095; 8'd218: r=209031220;
      8'd219: r=222615242; 8'd220: r=237082044; 8'd221: r=252488973;
      8'd222: r=268897122; 8'd223: r=286371562; 8'd224: r=304981612;
      8'd225: r=324801039; 8'd226: r=345908441; 8'd227: r=368387505;
      8'd228: r=392327395; 8'd229: r=417823051; 8'd230: r=444975534;
      8'd231: r=473892561; 8'd232: r=504688765; 8'd233: r=537486295;
      8'd234: r=572415181; 8'd235: r=609613936; 8'd236: r=649230091;
      8'd237: r=691420715; 8'd238: r=736353116; 8'd239: r=784205494;
      8'd240: r=835167579; 8'd241: r=889441492; 8'd242: r=947242410;
      8'd243: r=1008799556; 8'd244: r=1074357035; 8'd245: r=1144174799;
      8'd246: r=1218529724; 8'd247: r=1297716638; 8'd248: r=1382049587;
      8'd249: r=1471862937; 8'd250: r=1567512890; 8'd251: r=1669378712;
      8'd252: r=1777864346; 8'd253: r=1893399976; 8'd254: r=2016443766;
      default: r = 32'd2147483647;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/fcla_ctrl.sv =====
// fcla_ctrl: item sequencer for the floor curve line renderer.
// Depends on fcla_pkg.
module fcla_ctrl import fcla_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_fire,
  input  logic [1:0] in_op,
  input  logic       in_unused,
  input  logic       out_free,    // result register empty or draining
  input  fcla_sts_t  sts,
  output logic       s_ready,
  output fcla_cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_COMMIT = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t state, state_next;

  assign s_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_op)
            OP_START: cmd.start = 1'b1;
            OP_POST: begin
              if (!in_unused) begin
                cmd.post_load = 1'b1;
                state_next = ST_DIV;
              end
            end
            OP_COEF: begin
              cmd.coef_load = 1'b1;
              state_next = ST_MUL;
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.post_done = 1'b1;
        state_next = ST_IDLE;
      end
      ST_MUL: begin
        cmd.mul_load = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

endmodule

// ===== rtl/fcla_dp.sv =====
// fcla_dp: segment state, slope divider, Bresenham step and coefficient scaler.
// Depends on fcla_pkg.
module fcla_dp import fcla_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  fcla_cmd_t    cmd,
  output fcla_sts_t    sts,
  input  logic [2:0]   mult,
  input  logic [12:0]  half_block,
  input  logic [31:0]  coef,
  input  logic [15:0]  post_x,
  input  logic [7:0]   post_value,
  output logic [31:0]  res_value,
  output logic [11:0]  res_bin,
  output logic         res_oos
);

  logic [15:0] seg_start_x, seg_end_x, width_x, residual, error_acc;
  logic [7:0]  seg_end_y, cur_y;
  logic signed [8:0] base_slope, slope_step;
  logic [12:0] bin_counter;
  logic        first_of_segment;

  // post scaling
  logic [10:0] y_prod;
  logic [7:0]  y_sat;
  assign y_prod = {3'd0, post_value} * {8'd0, mult};
  assign y_sat  = (y_prod > {3'd0, Y_MAX}) ? Y_MAX : y_prod[7:0];

  // divider: |dy| (8 bits) / adx (16 bits), restoring, one bit per cycle
  logic [7:0]  dv_num, dv_quo, new_y;
  logic [15:0] dv_den, dv_rem, dv_try;
  logic [16:0] dv_sub;
  logic [2:0]  dv_cnt;
  logic        dv_neg, dv_valid;
  logic [15:0] new_x;
  logic signed [9:0] dy;
  logic [16:0] adx;

  assign dy  = $signed({2'b00, y_sat}) - $signed({2'b00, seg_end_y});
  assign adx = {1'b0, post_x} - {1'b0, seg_end_x};
  assign dv_try = {dv_rem[14:0], dv_num[7]};
  assign dv_sub = {1'b0, dv_try} - {1'b0, dv_den};
  assign sts.div_last = (dv_cnt == 3'd7);

  always_ff @(posedge clk) begin
    if (cmd.post_load) begin
      dv_num <= dy[9] ? 8'(-dy) : dy[7:0];
      dv_neg <= dy[9];
      dv_den <= adx[15:0];
      dv_valid <= !adx[16] && (adx[15:0] != 16'd0);
      dv_rem <= '0;
      dv_quo <= '0;
      dv_cnt <= '0;
      new_x <= post_x;
      new_y <= y_sat;
    end else if (cmd.div_step) begin
      dv_num <= {dv_num[6:0], 1'b0};
      dv_cnt <= dv_cnt + 3'd1;
      if (!dv_sub[16]) begin
        dv_rem <= dv_sub[15:0];
        dv_quo <= {dv_quo[6:0], 1'b1};
      end else begin
        dv_rem <= dv_try;
        dv_quo <= {dv_quo[6:0], 1'b0};
      end
    end
  end

  // Bresenham step
  logic        in_seg;
  logic [12:0] limit;
  logic [16:0] err_sum;
  logic [16:0] err_sub;
  logic signed [10:0] y_new;
  logic [7:0]  y_use;
  logic [15:0] err_next;

  assign limit = ({3'd0, half_block} < seg_end_x) ? half_block : seg_end_x[12:0];
  assign in_seg = (width_x != 16'd0) && ({3'd0, bin_counter} >= seg_start_x)
                  && (bin_counter < limit);
  assign err_sum = {1'b0, error_acc} + {1'b0, residual};
  assign err_sub = err_sum - {1'b0, width_x};

  always_comb begin
    err_next = error_acc;
    y_new = $signed({3'b000, cur_y});
    if (!first_of_segment) begin
      if (err_sum >= {1'b0, width_x}) begin
        err_next = err_sub[15:0];
        y_new = $signed({3'b000, cur_y}) + 11'(slope_step);
      end else begin
        err_next = err_sum[15:0];
        y_new = $signed({3'b000, cur_y}) + 11'(base_slope);
      end
    end
    if (y_new < 0) y_use = 8'd0;
    else if (y_new > 11'sd255) y_use = Y_MAX;
    else y_use = y_new[7:0];
  end

  // coefficient pipeline: register operands, then multiply and truncate
  logic signed [31:0] m_coef;
  logic [31:0] m_rom;
  logic        m_inside;
  logic [11:0] m_bin;
  logic signed [63:0] prod;
  assign prod = m_coef * $signed({1'b0, m_rom});
  logic signed [63:0] p_reg;
  logic signed [31:0] p_coef;
  logic        p_inside;
  logic [11:0] p_bin;

  always_ff @(posedge clk) begin
    if (cmd.coef_load) begin
      m_coef <= coef;
      m_rom <= db_rom(y_use);
      m_inside <= in_seg;
      m_bin <= bin_counter[11:0];
    end
    if (cmd.mul_load) begin
      p_reg <= prod;
      p_coef <= m_coef;
      p_inside <= m_inside;
      p_bin <= m_bin;
    end
    if (cmd.out_load) begin
      res_value <= p_inside ? p_reg[SHIFT+31:SHIFT] : p_coef;
      res_oos <= !p_inside;
      res_bin <= p_bin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_start_x <= '0; seg_end_x <= '0; seg_end_y <= '0; cur_y <= '0;
      base_slope <= '0; slope_step <= '0; residual <= '0; width_x <= '0;
      error_acc <= '0; bin_counter <= '0; first_of_segment <= 1'b1;
    end else if (cmd.start) begin
      seg_start_x <= '0; seg_end_x <= '0; seg_end_y <= y_sat; cur_y <= y_sat;
      base_slope <= '0; slope_step <= '0; residual <= '0; width_x <= '0;
      error_acc <= '0; bin_counter <= '0; first_of_segment <= 1'b1;
    end else if (cmd.post_done) begin
      seg_start_x <= seg_end_x;
      cur_y <= seg_end_y;
      error_acc <= '0;
      first_of_segment <= 1'b1;
      if (dv_valid) begin
        base_slope <= dv_neg ? -$signed({1'b0, dv_quo}) : $signed({1'b0, dv_quo});
        slope_step <= dv_neg ? -$signed({1'b0, dv_quo}) - 9'sd1
                             : $signed({1'b0, dv_quo}) + 9'sd1;
        residual <= dv_rem;
        width_x <= dv_den;
      end else begin
        base_slope <= '0; slope_step <= '0; residual <= '0; width_x <= '0;
      end
      seg_end_x <= new_x;
      seg_end_y <= new_y;
    end else if (cmd.coef_load) begin
      if (in_seg) begin
        first_of_segment <= 1'b0;
        error_acc <= err_next;
        cur_y <= y_use;
      end
      if (bin_counter != BIN_MAX) bin_counter <= bin_counter + 13'd1;
    end
  end

endmodule

// ===== rtl/floor_curve_line_apply_unit.sv =====
// floor_curve_line_apply_unit: top level of the floor curve line renderer.
// Depends on fcla_pkg, fcla_ctrl, fcla_dp.
//
// Scales spectral coefficients by a piecewise-linear floor curve. A frame
// start item sets the first end point, post items open line segments, and
// each coefficient item yields one result: coef times the dB ROM entry at the
// current curve y, shifted right by 15. Bins outside the current segment or
// beyond half_block pass through unchanged with out_of_segment set. A
// coefficient passes operand, multiply and result registers, waiting for
// a free result register; a used post runs the 8-step bit-serial slope
// divider and commits; start, unused post and reserved items stay in idle.
// The result register holds a finished result while the next item is accepted.
module floor_curve_line_apply_unit import fcla_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata: coef[31:0], post_x[47:32], post_value[55:48]
  input  logic [55:0] s_tdata,
  // s_tuser: op[1:0], post_unused[2]
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata: value[31:0], bin_index[43:32], zero fill
  output logic [47:0] m_tdata,
  // m_tuser: out_of_segment
  output logic        m_tuser
);

  logic [2:0]  mult;
  logic [12:0] half_block;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      mult <= 3'd1;
      half_block <= 13'd128;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        ADDR_MULT[0]: mult <= pwdata[2:0];
        default:      half_block <= pwdata[12:0];
      endcase
    end
  end
  assign prdata = paddr[2] ? {19'd0, half_block} : {29'd0, mult};

  fcla_cmd_t cmd;
  fcla_sts_t sts;
  logic in_fire, out_free;
  logic [31:0] res_value;
  logic [11:0] res_bin;
  logic        res_oos;

  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  fcla_ctrl u_ctrl (
    .clk, .rst, .in_fire,
    .in_op(s_tuser[1:0]), .in_unused(s_tuser[2]),
    .out_free, .sts, .s_ready(s_tready), .cmd
  );

  fcla_dp u_dp (
    .clk, .rst, .cmd, .sts, .mult, .half_block,
    .coef(s_tdata[31:0]), .post_x(s_tdata[47:32]), .post_value(s_tdata[55:48]),
    .res_value, .res_bin, .res_oos
  );

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (cmd.out_load) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  assign m_tdata = {4'd0, res_bin, res_value};
  assign m_tuser = res_oos;

endmodule
